### rtl/rspe_pkg.sv
`timescale 1ns / 1ps
package rspe_pkg;

   localparam int SYMBOL_BITS = 9;
   localparam logic [SYMBOL_BITS:0] FIELD_POLY = 10'h211;
   localparam logic [SYMBOL_BITS-1:0] ALPHA = 9'd2;
   localparam int MAX_PARITY = 64;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] data_symbol;
      logic                   data_last;
   } req_type;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] parity_symbol;
      logic                   parity_last;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } lfsr_ctrl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } out_ctrl_type;

   function automatic logic [SYMBOL_BITS-1:0] gf_mul(
      input logic [SYMBOL_BITS-1:0] a,
      input logic [SYMBOL_BITS-1:0] b
   );
      logic [SYMBOL_BITS:0]   aa;
      logic [SYMBOL_BITS-1:0] r;
      aa = {1'b0, a};
      r  = '0;
      for (int i = 0; i < SYMBOL_BITS; i++) begin
         if (b[i]) begin
            r = r ^ aa[SYMBOL_BITS-1:0];
         end
         aa = aa << 1;
         if (aa[SYMBOL_BITS]) begin
            aa = aa ^ FIELD_POLY;
         end
      end
      return r;
   endfunction

   // coefficient idx of the product of (x + alpha^i), i = 1 .. n
   function automatic logic [SYMBOL_BITS-1:0] gen_coef(input int n, input int idx);
      logic [SYMBOL_BITS-1:0] g [MAX_PARITY+1];
      logic [SYMBOL_BITS-1:0] root;
      for (int k = 0; k <= MAX_PARITY; k++) begin
         g[k] = '0;
      end
      g[0] = 9'd1;
      root = 9'd1;
      for (int i = 1; i <= n; i++) begin
         root = gf_mul(root, ALPHA);
         for (int j = i; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
      end
      return g[idx];
   endfunction

endpackage

### rtl/rspe_lfsr_cell.sv
`timescale 1ns / 1ps
module rspe_lfsr_cell
   import rspe_pkg::*;
#(
   parameter logic [SYMBOL_BITS-1:0] COEF = 9'd1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfsr_ctrl_type          ctrl,
   input  logic [SYMBOL_BITS-1:0] prev_value,
   input  logic [SYMBOL_BITS-1:0] feedback,
   output logic [SYMBOL_BITS-1:0] value,
   output logic [SYMBOL_BITS-1:0] next_value
);

   logic [SYMBOL_BITS-1:0] value_ff;
   logic [SYMBOL_BITS-1:0] value_in;

   assign next_value = prev_value ^ gf_mul(COEF, feedback);
   assign value      = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = ctrl.clear ? '0 : next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

### rtl/rspe_out_cell.sv
`timescale 1ns / 1ps
module rspe_out_cell
   import rspe_pkg::*;
(
   input  logic                   clock,
   input  out_ctrl_type           ctrl,
   input  logic [SYMBOL_BITS-1:0] load_value,
   input  logic [SYMBOL_BITS-1:0] shift_value,
   output logic [SYMBOL_BITS-1:0] value
);

   logic [SYMBOL_BITS-1:0] value_ff;
   logic [SYMBOL_BITS-1:0] value_in;

   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = load_value;
      end else if (ctrl.shift) begin
         value_in = shift_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/reed_solomon_parity_encoder_unit.sv
`timescale 1ns / 1ps
// latency: parity of a message starts in the cycle after its last data transfer
// throughput: one data symbol per cycle; each message then gives 2*CORRECTABLE_ERRORS
// parity symbols, one per cycle while rsp_ready is high, from a separate output shift chain
// a last symbol waits only while the previous parity run is still draining
// reset: synchronous, clears the parity chain and the output count
module reed_solomon_parity_encoder_unit
   import rspe_pkg::*;
#(
   parameter int CORRECTABLE_ERRORS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PARITY_COUNT = 2 * CORRECTABLE_ERRORS;
   localparam int CNT_BITS     = $clog2(PARITY_COUNT + 1);

   logic [SYMBOL_BITS-1:0] lfsr_value [PARITY_COUNT];
   logic [SYMBOL_BITS-1:0] lfsr_next  [PARITY_COUNT];
   logic [SYMBOL_BITS-1:0] out_value  [PARITY_COUNT];
   logic [SYMBOL_BITS-1:0] feedback;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [CNT_BITS-1:0]    cnt_in;
   logic                   req_xfer;
   logic                   rsp_xfer;
   lfsr_ctrl_type          lfsr_ctrl;
   out_ctrl_type           out_ctrl;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign req_ready = !req_data.data_last || (cnt_ff == '0)
                      || ((cnt_ff == CNT_BITS'(1)) && rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   assign feedback = req_data.data_symbol ^ lfsr_value[PARITY_COUNT-1];

   assign lfsr_ctrl.shift = req_xfer;
   assign lfsr_ctrl.clear = req_xfer && req_data.data_last;
   assign out_ctrl.load   = req_xfer && req_data.data_last;
   assign out_ctrl.shift  = rsp_xfer;

   generate
      for (genvar j = 0; j < PARITY_COUNT; j++) begin : g_cell
         logic [SYMBOL_BITS-1:0] lfsr_prev;
         logic [SYMBOL_BITS-1:0] out_prev;
         if (j == 0) begin : g_first
            assign lfsr_prev = '0;
            assign out_prev  = '0;
         end else begin : g_rest
            assign lfsr_prev = lfsr_value[j-1];
            assign out_prev  = out_value[j-1];
         end

         rspe_lfsr_cell #(
            .COEF(gen_coef(PARITY_COUNT, j))
         ) u_lfsr_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (lfsr_ctrl),
            .prev_value (lfsr_prev),
            .feedback   (feedback),
            .value      (lfsr_value[j]),
            .next_value (lfsr_next[j])
         );

         rspe_out_cell u_out_cell (
            .clock       (clock),
            .ctrl        (out_ctrl),
            .load_value  (lfsr_next[j]),
            .shift_value (out_prev),
            .value       (out_value[j])
         );
      end
   endgenerate

   assign rsp_data.parity_symbol = out_value[PARITY_COUNT-1];
   assign rsp_data.parity_last   = (cnt_ff == CNT_BITS'(1));

   always_comb begin
      cnt_in = cnt_ff;
      if (out_ctrl.load) begin
         cnt_in = CNT_BITS'(PARITY_COUNT);
      end else if (rsp_xfer) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
